/* design/tcw_pkg.sv */
package tcw_pkg;

	// Internal widths cover the largest supported screen (255 columns, 63 rows).
	localparam int COL_W = 8;
	localparam int ROW_W = 6;
	localparam int IDX_W = 14;

	// Widths of the result ports.
	localparam int CELL_INDEX_W = 11;
	localparam int CELL_W = 16;
	localparam int CURSOR_COL_W = 7;
	localparam int CURSOR_ROW_W = 5;

	localparam logic [7:0] NL_BYTE = 8'h0A;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

	typedef logic [7:0] char_t;

	// One classified character on its way from the front to the back.
	typedef struct packed {
		logic is_char;
		char_t ch;
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic wrote_cell;
		logic [CELL_INDEX_W-1:0] cell_index;
		logic [CELL_W-1:0] cell_value;
		logic [CURSOR_COL_W-1:0] cursor_col;
		logic [CURSOR_ROW_W-1:0] cursor_row;
		logic cleared;
	} res_t;

endpackage

/* design/tcw_front.sv */
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tcw_pkg::char_t ch,
	input logic init_busy,
	input logic q_full,
	output logic full,
	output logic cmd_push,
	output tcw_pkg::cmd_t cmd
);
	import tcw_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [IDX_W-1:0] base_q;
	logic [COL_W-1:0] col_inc;
	logic [COL_W-1:0] col_n;
	logic [ROW_W-1:0] row_n;
	logic [IDX_W-1:0] base_n;
	logic is_nl;
	logic clr;

	assign full = q_full | init_busy;
	assign cmd_push = push & ~full;
	assign is_nl = (ch == NL_BYTE);
	assign col_inc = col_q + COL_W'(1);

	always_comb begin
		col_n = col_inc;
		row_n = row_q;
		base_n = base_q;
		if (is_nl || col_inc == COL_W'(COLUMNS)) begin
			col_n = '0;
			row_n = row_q + ROW_W'(1);
			base_n = base_q + IDX_W'(COLUMNS);
		end
		clr = (row_n == ROW_W'(ROWS));
		if (clr) begin
			col_n = '0;
			row_n = '0;
			base_n = '0;
		end
	end

	always_comb begin
		cmd.is_char = ~is_nl;
		cmd.ch = ch;
		cmd.idx = base_q + IDX_W'(col_q);
		cmd.col = col_n;
		cmd.row = row_n;
		cmd.clr = clr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			base_q <= '0;
		end else if (cmd_push) begin
			col_q <= col_n;
			row_q <= row_n;
			base_q <= base_n;
		end
	end

endmodule

/* design/tcw_cmdq.sv */
module tcw_cmdq (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input tcw_pkg::cmd_t wr_data,
	output logic q_full,
	input logic rd_en,
	output logic rd_valid,
	output tcw_pkg::cmd_t rd_data
);
	import tcw_pkg::*;

	cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign q_full = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!q_full || rd_en))
		else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("command queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 2'd1))
		else $error("command queue fill level lost a write");
`endif

endmodule

/* design/tcw_back.sv */
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input tcw_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic init_busy,
	output logic out_valid,
	input logic pop,
	output tcw_pkg::res_t res
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_WR,
		ST_SWEEP
	} st_t;

	st_t state_q;
	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic [AW-1:0] ptr_q;
	logic done_q;
	logic wv_s1;
	logic [AW-1:0] waddr_s1;
	cmd_t cmd_q;
	logic out_valid_q;
	res_t res_q;

	logic slot_free;
	logic load_res;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;

	assign slot_free = ~out_valid_q | pop;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign load_res = (state_q == ST_WR) && slot_free;
	assign init_busy = (state_q == ST_INIT);
	assign out_valid = out_valid_q;
	assign res = res_q;

	always_comb begin
		rd_en = cmd_pop || (state_q == ST_SWEEP && !done_q);
		rd_addr = (state_q == ST_SWEEP) ? ptr_q : cmd.idx[AW-1:0];
		wr_en = 1'b0;
		wr_addr = ptr_q;
		wr_data = BLANK_CELL;
		unique case (state_q)
			ST_INIT: begin
				wr_en = 1'b1;
			end
			ST_WR: begin
				wr_en = load_res && cmd_q.is_char;
				wr_addr = cmd_q.idx[AW-1:0];
				wr_data = {rdata_q[CELL_W-1:8], cmd_q.ch};
			end
			ST_SWEEP: begin
				wr_en = wv_s1;
				wr_addr = waddr_s1;
				wr_data = {rdata_q[CELL_W-1:8], SPACE_BYTE};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Screen store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q <= '0;
			done_q <= 1'b0;
			wv_s1 <= 1'b0;
			waddr_s1 <= '0;
			cmd_q <= '0;
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			wv_s1 <= (state_q == ST_SWEEP) && !done_q;
			waddr_s1 <= ptr_q;
			if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (ptr_q == LAST) begin
						ptr_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (load_res) begin
						out_valid_q <= 1'b1;
						res_q.wrote_cell <= cmd_q.is_char;
						res_q.cell_index <= cmd_q.is_char ?
							CELL_INDEX_W'(cmd_q.idx) : '0;
						res_q.cell_value <= cmd_q.is_char ?
							{rdata_q[CELL_W-1:8], cmd_q.ch} : '0;
						res_q.cursor_col <= CURSOR_COL_W'(cmd_q.col);
						res_q.cursor_row <= CURSOR_ROW_W'(cmd_q.row);
						res_q.cleared <= cmd_q.clr;
						if (cmd_q.clr) begin
							ptr_q <= '0;
							done_q <= 1'b0;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SWEEP: begin
					if (!done_q) begin
						if (ptr_q == LAST) begin
							done_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end else if (!wv_s1) begin
						ptr_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!out_valid_q || pop))
		else $error("result register overwritten before it was taken");
	a_no_cmd_while_sweeping: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP || state_q == ST_INIT) |-> !cmd_pop)
		else $error("command taken while the screen store is being swept");
	a_clear_leads_to_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(load_res && cmd_q.clr) |=> (state_q == ST_SWEEP && out_valid_q))
		else $error("screen fill did not start the blanking sweep");
`endif

endmodule

/* design/text_mode_character_writer.sv */
// Text-mode character writer for a COLUMNS x ROWS screen of 16-bit cells (attribute in
// the high byte, character in the low byte). Each transfer on the input side carries one
// character byte; each transfer on the result side reports the cell that was written, the
// new cursor position and whether the screen was blanked. A newline byte (0x0A) only
// moves the cursor and reports no cell. Every other byte, including 0x00 and 0x80 to 0xFF,
// replaces the character byte under the cursor and keeps the attribute. When the cursor
// runs off the last row, every character becomes a space and the cursor returns home.
// Timing: in the back end a character passes two states, ST_IDLE, which reads the cell
// from the screen store, and ST_WR, which writes it back and loads the result register
// once that register is free; the next character is taken only back in ST_IDLE.
// A two-entry command queue sits between the front end, which tracks the cursor and
// classifies bytes, and the back end, so input transfers keep flowing while a result
// waits to be popped, until the queue fills. After reset the store is filled with
// 0x0720, and full stays high until the fill is done. A character or newline that fills
// the screen starts a blanking sweep of the store; its result is available at once, and
// the next character is processed after the sweep finishes.
module text_mode_character_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tcw_pkg::char_t ch,
	output logic empty,
	input logic pop,
	output logic wrote_cell,
	output logic [tcw_pkg::CELL_INDEX_W-1:0] cell_index,
	output logic [tcw_pkg::CELL_W-1:0] cell_value,
	output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
	output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
	output logic cleared
);
	import tcw_pkg::*;

	logic init_busy;
	logic q_full;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd_head;
	logic out_valid;
	res_t res;

	// The front end owns the cursor, so it can classify and address a character as soon
	// as the transfer happens, without waiting for the screen store.
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.ch(ch),
		.init_busy(init_busy),
		.q_full(q_full),
		.full(full),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	tcw_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_push),
		.wr_data(cmd_in),
		.q_full(q_full),
		.rd_en(cmd_pop),
		.rd_valid(cmd_valid),
		.rd_data(cmd_head)
	);

	// The back end performs the read-modify-write on the screen store, the blanking
	// sweeps, and holds the result register.
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.pop(pop),
		.res(res)
	);

	assign empty = ~out_valid;
	assign wrote_cell = res.wrote_cell;
	assign cell_index = res.cell_index;
	assign cell_value = res.cell_value;
	assign cursor_col = res.cursor_col;
	assign cursor_row = res.cursor_row;
	assign cleared = res.cleared;

`ifndef SYNTH
	a_full_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> full)
		else $error("input accepted while the screen store is initializing");
	a_cursor_home_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && cleared) |-> (cursor_col == '0 && cursor_row == '0))
		else $error("blanking result does not report the cursor at home");
	a_newline_writes_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !wrote_cell) |-> (cell_index == '0 && cell_value == '0))
		else $error("newline result reports a cell");
`endif

endmodule

/* verif/text_mode_character_writer_test.sv */
module text_mode_character_writer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	// Screen geometry used by the block and by the local screen model.
	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;

	// Rough number of characters pushed over the whole run.
	localparam int ITEM_TARGET = 1800;

	// The block is allowed to sit without any transfer for the reset fill of the
	// store (one cell per cycle) or for a blanking sweep (one cell per cycle plus
	// a little), on top of the longest idle draws on both sides. The limit below
	// is several times that.
	localparam int STALL_LIMIT = 20000;

	// Cycles kept after the last expected result, to catch stray results.
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	char_t ch;
	logic empty;
	logic pop;
	logic wrote_cell;
	logic [CELL_INDEX_W-1:0] cell_index;
	logic [CELL_W-1:0] cell_value;
	logic [CURSOR_COL_W-1:0] cursor_col;
	logic [CURSOR_ROW_W-1:0] cursor_row;
	logic cleared;

	// Local copy of the screen and the cursor, advanced once per accepted character.
	int cur_col;
	int cur_row;
	logic [CELL_W-1:0] screen_words [CELLS];

	// Results predicted for accepted characters, oldest first.
	res_t pending_results[$];

	int failures = 0;
	int items_sent = 0;
	int results_seen = 0;

	// When a side is eager it does not idle at all; each side flips this now and
	// then so that long back-to-back stretches alternate with random gaps.
	bit sender_eager = 1'b0;
	bit receiver_eager = 1'b0;

	text_mode_character_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.ch(ch),
		.empty(empty),
		.pop(pop),
		.wrote_cell(wrote_cell),
		.cell_index(cell_index),
		.cell_value(cell_value),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.cleared(cleared)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Prints one character on the local screen and returns the result the block
	// must report for it. A newline only moves the cursor; any other byte keeps
	// the attribute of the cell and replaces its character. Running off the last
	// row turns every character into a space and homes the cursor.
	function automatic res_t print_char(input char_t c);
		res_t r;
		int idx;
		r = '0;
		if (c == NL_BYTE) begin
			cur_col = 0;
			cur_row++;
		end else begin
			idx = cur_row * COLUMNS + cur_col;
			screen_words[idx] = {screen_words[idx][CELL_W-1:8], c};
			r.wrote_cell = 1'b1;
			r.cell_index = CELL_INDEX_W'(idx);
			r.cell_value = screen_words[idx];
			cur_col++;
		end
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= ROWS) begin
			foreach (screen_words[k])
				screen_words[k] = {screen_words[k][CELL_W-1:8], SPACE_BYTE};
			cur_col = 0;
			cur_row = 0;
			r.cleared = 1'b1;
		end
		r.cursor_col = CURSOR_COL_W'(cur_col);
		r.cursor_row = CURSOR_ROW_W'(cur_row);
		return r;
	endfunction

	function automatic string describe(input res_t r);
		return $sformatf("wrote_cell=%0d cell_index=%0d cell_value=%h cursor=%0d,%0d cleared=%0d",
			r.wrote_cell, r.cell_index, r.cell_value, r.cursor_col, r.cursor_row, r.cleared);
	endfunction

	// Every failure is counted; only the first ten are described.
	function automatic void note_failure(input string what);
		failures++;
		if (failures <= 10)
			$display("ERROR: %s", what);
	endfunction

	// Number of idle cycles before the next transfer on one side.
	function automatic int draw_wait(inout bit eager);
		if ($urandom_range(0, 39) == 0)
			eager = !eager;
		return eager ? 0 : int'($urandom_range(0, 9));
	endfunction

	// Any byte but a newline, so that text lines keep their intended length.
	function automatic char_t random_glyph();
		char_t c;
		c = char_t'($urandom_range(0, 255));
		while (c == NL_BYTE)
			c = char_t'($urandom_range(0, 255));
		return c;
	endfunction

	// Offers one character and returns at the edge where it is taken. Push is left
	// high so that a following character with no gap keeps the queue busy; it is
	// dropped only when a gap is drawn or when the sender waits for a drain.
	task automatic send_char(input char_t c);
		int gap;
		gap = draw_wait(sender_eager);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_results.push_back(print_char(c));
		items_sent++;
	endtask

	// Holds the sender off until every predicted result has been popped.
	task automatic wait_for_drain();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Corner bytes: zero, the top of the range, bytes with the high bit set, 0x7F, a
	// space, control bytes on either side of newline, and newlines back to back.
	task automatic test_character_extremes();
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h80);
		send_char(8'h7F);
		send_char(8'h0B);
		send_char(SPACE_BYTE);
		send_char(NL_BYTE);
		send_char(NL_BYTE);
		send_char(8'h09);
	endtask

	// Newlines alone walk the cursor off the last row, and the final one must
	// blank the screen without reporting a cell.
	task automatic test_newline_clear();
		int lines_left;
		lines_left = ROWS - cur_row;
		repeat (lines_left)
			send_char(NL_BYTE);
	endtask

	// Move to the last row, then fill it. The character in the bottom-right cell
	// is reported as written and the same transfer reports the blanking.
	task automatic test_last_cell_clear();
		int lines_left;
		lines_left = ROWS - 1 - cur_row;
		repeat (lines_left)
			send_char(NL_BYTE);
		repeat (COLUMNS)
			send_char(random_glyph());
	endtask

	// Random text shaped as lines: mostly short lines, some long ones, some full
	// lines that wrap on their own, and a share of bytes drawn from the whole
	// range. The screen fills up and gets blanked several times along the way.
	task automatic test_random_text();
		int kind;
		int len;
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				send_char(char_t'($urandom_range(0, 255)));
			end else if (kind < 65) begin
				len = $urandom_range(0, 10);
				repeat (len)
					send_char(random_glyph());
				send_char(NL_BYTE);
			end else if (kind < 85) begin
				repeat (COLUMNS)
					send_char(random_glyph());
			end else begin
				len = $urandom_range(11, COLUMNS - 1);
				repeat (len)
					send_char(random_glyph());
				send_char(NL_BYTE);
			end
			if ($urandom_range(0, 49) == 0)
				wait_for_drain();
		end
	endtask

	// Pops results with random stalls and compares each one with the oldest
	// prediction. Outputs are read right after the edge at which the transfer
	// happens, so they still hold the values the block presented at that edge.
	initial begin : result_checker
		int gap;
		res_t got;
		res_t want;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_wait(receiver_eager);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got.wrote_cell = wrote_cell;
			got.cell_index = cell_index;
			got.cell_value = cell_value;
			got.cursor_col = cursor_col;
			got.cursor_row = cursor_row;
			got.cleared = cleared;
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result %0d with nothing expected: %s",
					results_seen, describe(got)));
			end else begin
				want = pending_results.pop_front();
				if (got.wrote_cell !== want.wrote_cell || got.cell_index !== want.cell_index
						|| got.cell_value !== want.cell_value
						|| got.cursor_col !== want.cursor_col
						|| got.cursor_row !== want.cursor_row
						|| got.cleared !== want.cleared)
					note_failure($sformatf("result %0d expected %s, actual %s",
						results_seen, describe(want), describe(got)));
			end
		end
	end

	// Ends the run if neither side completes a transfer for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("text_mode_character_writer verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		ch = '0;
		cur_col = 0;
		cur_row = 0;
		foreach (screen_words[k])
			screen_words[k] = BLANK_CELL;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The block fills its store after reset and holds full meanwhile, so the
		// first character simply waits for the queue to open.
		test_character_extremes();
		wait_for_drain();
		test_newline_clear();
		test_last_cell_clear();
		wait_for_drain();
		test_random_text();
		wait_for_drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("text_mode_character_writer verification clean");
		else
			$display("text_mode_character_writer verification failed");
		$finish;
	end

endmodule
